[hw/rtl/rcbr_pkg.sv]
package rcbr_pkg;

  localparam int SENSORS      = 5;
  localparam int CHARGE_TICKS = 10;
  localparam int LINE_W       = 5;
  localparam int TIME_W       = 16;
  localparam int CNT_W        = ($clog2(SENSORS + 1) > 3) ? $clog2(SENSORS + 1) : 3;

  localparam logic [TIME_W-1:0] WHITE_RESET  = 16'd9999;
  localparam logic [TIME_W-1:0] THRESH_RESET = 16'd800;
  localparam logic [TIME_W-1:0] TIME_MAX     = 16'hFFFF;
  localparam logic [3:0]        CHARGE_LOAD  = 4'(CHARGE_TICKS);

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_DETECT = 2'd1;
  localparam logic [1:0] MODE_CALIB  = 2'd2;

  localparam logic [1:0] DET_NONE    = 2'd0;
  localparam logic [1:0] DET_MINE    = 2'd1;
  localparam logic [1:0] DET_CONTROL = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_CHARGE  = 2'd1,
    PH_MEASURE = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [LINE_W-1:0] sensor_lines;
  } item_t;

  typedef struct packed {
    logic       emitter_on;
    logic       charge_lines;
    logic       busy_res;
    logic       done_res;
    logic [1:0] detection;
    logic [2:0] dark_count;
  } result_t;

endpackage

[hw/rtl/rcbr_core.sv]
module rcbr_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  rcbr_pkg::item_t   item,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  output rcbr_pkg::result_t res
);

  localparam int N  = rcbr_pkg::SENSORS;
  localparam int TW = rcbr_pkg::TIME_W;
  localparam int CW = rcbr_pkg::CNT_W;

  logic [TW-1:0] threshold;
  logic [TW-1:0] white_level [N];
  logic [TW-1:0] measured_time [N];
  logic [N-1:0]  finished_mask;
  rcbr_pkg::phase_t phase;
  logic [3:0]    charge_left;
  logic [TW-1:0] elapsed;
  logic          calibrating;

  logic [TW-1:0] white_level_next [N];
  logic [TW-1:0] measured_time_next [N];
  logic [N-1:0]  finished_mask_next;
  rcbr_pkg::phase_t phase_next;
  logic [3:0]    charge_left_next;
  logic [TW-1:0] elapsed_next;
  logic          calibrating_next;

  logic [TW:0]   limit [N];
  logic [N+rcbr_pkg::LINE_W-1:0] lines_ext;
  logic [N-1:0]  level;
  logic [CW-1:0] cnt;
  logic          done;
  logic [1:0]    det;
  logic [2:0]    dark;
  logic          start;

  // Sensors beyond the physical lines read as low.
  assign lines_ext = {{N{1'b0}}, item.sensor_lines};
  assign level     = lines_ext[N-1:0];
  assign start     = (item.mode == rcbr_pkg::MODE_DETECT) ||
                     (item.mode == rcbr_pkg::MODE_CALIB);

  always_comb begin
    for (int i = 0; i < N; i++) begin
      limit[i] = {1'b0, white_level[i]} + {1'b0, threshold};
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      white_level_next[i]   = white_level[i];
      measured_time_next[i] = measured_time[i];
    end
    finished_mask_next = finished_mask;
    phase_next         = phase;
    charge_left_next   = charge_left;
    elapsed_next       = elapsed;
    calibrating_next   = calibrating;
    done               = 1'b0;
    det                = rcbr_pkg::DET_NONE;
    dark               = 3'd0;
    cnt                = '0;

    if (start) begin
      if (phase == rcbr_pkg::PH_IDLE) begin
        phase_next         = rcbr_pkg::PH_CHARGE;
        charge_left_next   = rcbr_pkg::CHARGE_LOAD;
        calibrating_next   = (item.mode == rcbr_pkg::MODE_CALIB);
        elapsed_next       = '0;
        finished_mask_next = '0;
      end
    end else begin
      unique case (phase)
        rcbr_pkg::PH_IDLE: begin
        end
        rcbr_pkg::PH_CHARGE: begin
          if (charge_left != 4'd0) begin
            charge_left_next = charge_left - 4'd1;
          end
          if (charge_left_next == 4'd0) begin
            phase_next   = rcbr_pkg::PH_MEASURE;
            elapsed_next = '0;
          end
        end
        rcbr_pkg::PH_MEASURE: begin
          for (int i = 0; i < N; i++) begin
            if (!finished_mask[i]) begin
              measured_time_next[i] = elapsed;
              if (!level[i] || ({1'b0, elapsed} > limit[i]) ||
                  (elapsed == rcbr_pkg::TIME_MAX)) begin
                finished_mask_next[i] = 1'b1;
              end
            end
          end
          if (elapsed != rcbr_pkg::TIME_MAX) begin
            elapsed_next = elapsed + 1'b1;
          end
          if (&finished_mask_next) begin
            done       = 1'b1;
            phase_next = rcbr_pkg::PH_IDLE;
            if (calibrating) begin
              for (int i = 0; i < N; i++) begin
                white_level_next[i] = measured_time_next[i];
              end
            end else begin
              for (int i = 0; i < N; i++) begin
                if ({1'b0, measured_time_next[i]} >= limit[i]) begin
                  cnt = cnt + 1'b1;
                end
              end
              if (cnt >= CW'(2)) begin
                det = (cnt == CW'(N)) ? rcbr_pkg::DET_CONTROL : rcbr_pkg::DET_MINE;
              end
              dark = (cnt > CW'(7)) ? 3'd7 : cnt[2:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.emitter_on   = (phase_next != rcbr_pkg::PH_IDLE);
    res.charge_lines = (phase_next == rcbr_pkg::PH_CHARGE);
    res.busy_res     = (phase_next != rcbr_pkg::PH_IDLE);
    res.done_res     = done;
    res.detection    = det;
    res.dark_count   = dark;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= rcbr_pkg::THRESH_RESET;
      finished_mask <= '0;
      phase         <= rcbr_pkg::PH_IDLE;
      charge_left   <= 4'd0;
      elapsed       <= '0;
      calibrating   <= 1'b0;
      for (int i = 0; i < N; i++) begin
        white_level[i]   <= rcbr_pkg::WHITE_RESET;
        measured_time[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        threshold <= cfg_wr_data;
      end
      if (advance) begin
        finished_mask <= finished_mask_next;
        phase         <= phase_next;
        charge_left   <= charge_left_next;
        elapsed       <= elapsed_next;
        calibrating   <= calibrating_next;
        for (int i = 0; i < N; i++) begin
          white_level[i]   <= white_level_next[i];
          measured_time[i] <= measured_time_next[i];
        end
      end
    end
  end

endmodule

[hw/rtl/rc_reflectance_bar_reader_unit.sv]
// An item accepted into the input register is processed once the result
// register can take it, and its result is then held in the result register
// until it is taken.
// Throughput: one item per cycle while the result side does not stall, with the
// input register and the result register both filled while the result side stalls.
// Reset (rst, synchronous, active high) empties both registers, sets the
// threshold to 800, all white levels to 9999 and returns the reader to idle.
module rc_reflectance_bar_reader_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  rcbr_pkg::item_t   in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output rcbr_pkg::result_t out_item,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data
);

  logic              item_valid;
  rcbr_pkg::item_t   item;
  logic              advance;
  rcbr_pkg::result_t res;

  // The held item is processed whenever the result register can take it.
  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= res;
    end
  end

  rcbr_core u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res         (res)
  );

endmodule

[hw/rtl/rcbr_checker.sv]
module rcbr_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input rcbr_pkg::result_t out_item
);

  // A run that finishes leaves the reader idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.done_res |-> !out_item.busy_res && !out_item.emitter_on)
    else $error("done item shows a busy reader");

  // Charging only happens inside a run.
  a_charge_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.charge_lines |-> out_item.busy_res)
    else $error("charge without a run");

  // A classification appears only on the item that ends a run.
  a_det_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.detection != rcbr_pkg::DET_NONE) |-> out_item.done_res)
    else $error("detection outside the end of a run");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("registers not empty after reset");

endmodule

bind rc_reflectance_bar_reader_unit rcbr_checker u_rcbr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

[tb/tb_rc_reflectance_bar_reader_unit.sv]
`timescale 1ns / 100ps

module tb_rc_reflectance_bar_reader_unit;
  import rcbr_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int MINE_MIN = 2;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_ITEMS = 650;

  localparam result_t RES_IDLE = '0;
  localparam result_t RES_CHARGE = '{emitter_on: 1'b1, charge_lines: 1'b1, busy_res: 1'b1,
                                     done_res: 1'b0, detection: DET_NONE, dark_count: 3'd0};
  localparam result_t RES_MEASURE = '{emitter_on: 1'b1, charge_lines: 1'b0, busy_res: 1'b1,
                                      done_res: 1'b0, detection: DET_NONE, dark_count: 3'd0};
  localparam result_t RES_DONE_NONE = '{emitter_on: 1'b0, charge_lines: 1'b0, busy_res: 1'b0,
                                        done_res: 1'b1, detection: DET_NONE, dark_count: 3'd0};

  typedef struct packed {
    logic [1:0]        mode;
    logic [LINE_W-1:0] lines;
    logic [7:0]        reps;
    logic              typed;
    result_t           want;
  } dir_row_t;

  // Rows with typed clear are checked against the predictor.
  localparam int DIR_ROWS = 12;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{MODE_TICK,   5'b00000, 8'd1,  1'b1, RES_IDLE},
    '{MODE_UNUSED, 5'b11111, 8'd1,  1'b1, RES_IDLE},
    '{MODE_DETECT, 5'b00000, 8'd1,  1'b1, RES_CHARGE},
    '{MODE_DETECT, 5'b11111, 8'd1,  1'b1, RES_CHARGE},
    '{MODE_CALIB,  5'b11111, 8'd1,  1'b1, RES_CHARGE},
    '{MODE_TICK,   5'b11111, 8'd9,  1'b1, RES_CHARGE},
    '{MODE_TICK,   5'b11111, 8'd1,  1'b1, RES_MEASURE},
    '{MODE_TICK,   5'b00000, 8'd1,  1'b1, RES_DONE_NONE},
    '{MODE_CALIB,  5'b00000, 8'd1,  1'b1, RES_CHARGE},
    '{MODE_UNUSED, 5'b01010, 8'd10, 1'b0, RES_IDLE},
    '{MODE_TICK,   5'b11110, 8'd1,  1'b0, RES_IDLE},
    '{MODE_TICK,   5'b00000, 8'd1,  1'b0, RES_IDLE}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  item_t       in_item = '0;
  logic        out_stall = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_stall;
  logic        out_valid;
  result_t     out_item;

  // Typed expectation that travels with the item being offered.
  logic        cur_typed = 1'b0;
  result_t     cur_want = '0;

  int errors = 0;
  int run_items = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  result_t pending_results [$];

  // Shadow state of the reader.
  logic [TIME_W-1:0]  thr_copy;
  logic [TIME_W-1:0]  white_copy [SENSORS];
  logic [TIME_W-1:0]  meas_copy [SENSORS];
  logic [SENSORS-1:0] fin_copy;
  phase_t             phase_copy;
  logic [3:0]         charge_copy;
  logic [TIME_W-1:0]  elapsed_copy;
  logic               calib_copy;

  always #5 clk = ~clk;

  rc_reflectance_bar_reader_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  function automatic void reset_reader();
    thr_copy = THRESH_RESET;
    for (int i = 0; i < SENSORS; i++) begin
      white_copy[i] = WHITE_RESET;
      meas_copy[i] = '0;
    end
    fin_copy = '0;
    phase_copy = PH_IDLE;
    charge_copy = '0;
    elapsed_copy = '0;
    calib_copy = 1'b0;
  endfunction

  function automatic result_t predict_bar_item(item_t it);
    result_t r;
    logic [TIME_W:0] limit;
    logic level;
    int dark;
    logic done;
    r = '0;
    done = 1'b0;
    if (it.mode == MODE_DETECT || it.mode == MODE_CALIB) begin
      // A command during a run is dropped and does not count as a tick.
      if (phase_copy == PH_IDLE) begin
        phase_copy = PH_CHARGE;
        charge_copy = CHARGE_LOAD;
        calib_copy = (it.mode == MODE_CALIB);
        elapsed_copy = '0;
        fin_copy = '0;
      end
    end else if (phase_copy == PH_CHARGE) begin
      if (charge_copy != 0) charge_copy--;
      if (charge_copy == 0) begin
        phase_copy = PH_MEASURE;
        elapsed_copy = '0;
      end
    end else if (phase_copy == PH_MEASURE) begin
      for (int i = 0; i < SENSORS; i++) begin
        if (!fin_copy[i]) begin
          level = (i < LINE_W) ? it.sensor_lines[i] : 1'b0;
          limit = {1'b0, white_copy[i]} + {1'b0, thr_copy};
          meas_copy[i] = elapsed_copy;
          if (!level || {1'b0, elapsed_copy} > limit || elapsed_copy == TIME_MAX)
            fin_copy[i] = 1'b1;
        end
      end
      if (elapsed_copy != TIME_MAX) elapsed_copy++;
      if (&fin_copy) begin
        done = 1'b1;
        phase_copy = PH_IDLE;
        if (calib_copy) begin
          for (int i = 0; i < SENSORS; i++) white_copy[i] = meas_copy[i];
        end else begin
          dark = 0;
          for (int i = 0; i < SENSORS; i++)
            if ({1'b0, meas_copy[i]} >= {1'b0, white_copy[i]} + {1'b0, thr_copy}) dark++;
          if (dark >= MINE_MIN) r.detection = (dark == SENSORS) ? DET_CONTROL : DET_MINE;
          r.dark_count = (dark > 7) ? 3'd7 : 3'(dark);
        end
      end
    end
    r.emitter_on = (phase_copy != PH_IDLE);
    r.charge_lines = (phase_copy == PH_CHARGE);
    r.busy_res = (phase_copy != PH_IDLE);
    r.done_res = done;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t predicted;
    result_t want;
    if (!rst && in_valid && !in_stall) begin
      predicted = predict_bar_item(in_item);
      pending_results.push_back(cur_typed ? cur_want : predicted);
    end
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result item arrived with nothing pending");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.emitter_on !== want.emitter_on) begin
          $error("emitter_on: expected %0d, got %0d", want.emitter_on, out_item.emitter_on);
          errors++;
        end
        if (out_item.charge_lines !== want.charge_lines) begin
          $error("charge_lines: expected %0d, got %0d", want.charge_lines,
                 out_item.charge_lines);
          errors++;
        end
        if (out_item.busy_res !== want.busy_res) begin
          $error("busy_res: expected %0d, got %0d", want.busy_res, out_item.busy_res);
          errors++;
        end
        if (out_item.done_res !== want.done_res) begin
          $error("done_res: expected %0d, got %0d", want.done_res, out_item.done_res);
          errors++;
        end
        if (out_item.detection !== want.detection) begin
          $error("detection: expected %0d, got %0d", want.detection, out_item.detection);
          errors++;
        end
        if (out_item.dark_count !== want.dark_count) begin
          $error("dark_count: expected %0d, got %0d", want.dark_count, out_item.dark_count);
          errors++;
        end
      end
    end
  end

  // The result side switches between free flow, light, heavy and long stalls.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(32, 256);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 6);
      default: out_stall <= ((stall_left % 24) < 14);
    endcase
  end

  task automatic send_item(logic [1:0] mode, logic [LINE_W-1:0] lines, logic typed,
                           result_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= '{mode: mode, sensor_lines: lines};
    cur_typed <= typed;
    cur_want <= want;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [15:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    thr_copy = value;
  endtask

  // One run with random content: each line stays high until its own drop tick.
  task automatic measure_run(logic calib, int dark_pct);
    int drop [SENSORS];
    int last;
    int ticks;
    logic [LINE_W-1:0] lines;
    result_t none;
    none = '0;
    last = 0;
    lines = '0;
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3))
        send_item($urandom_range(0, 1) ? MODE_UNUSED : MODE_TICK, LINE_W'($urandom), 1'b0, none);
    send_item(calib ? MODE_CALIB : MODE_DETECT, LINE_W'($urandom), 1'b0, none);
    run_items++;
    ticks = 0;
    while (ticks < CHARGE_TICKS) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item($urandom_range(0, 1) ? MODE_CALIB : MODE_DETECT, LINE_W'($urandom), 1'b0,
                  none);
      end else begin
        send_item(($urandom_range(0, 4) == 0) ? MODE_UNUSED : MODE_TICK, LINE_W'($urandom),
                  1'b0, none);
        ticks++;
        run_items++;
      end
    end
    for (int i = 0; i < SENSORS; i++) begin
      if (calib)
        drop[i] = $urandom_range(0, 20);
      else
        drop[i] = ($urandom_range(0, 99) < dark_pct) ? $urandom_range(18, 60)
                                                      : $urandom_range(0, 15);
      if (drop[i] > last) last = drop[i];
    end
    for (int t = 0; t <= last; t++) begin
      if ($urandom_range(0, 19) == 0)
        send_item($urandom_range(0, 1) ? MODE_CALIB : MODE_DETECT, LINE_W'($urandom), 1'b0,
                  none);
      for (int i = 0; i < SENSORS; i++)
        if (i < LINE_W)
          lines[i] = (t < drop[i]) ? 1'b1 : (t == drop[i]) ? 1'b0 : 1'($urandom);
      send_item(($urandom_range(0, 7) == 0) ? MODE_UNUSED : MODE_TICK, lines, 1'b0, none);
      run_items++;
    end
  endtask

  initial begin
    int phase_idx;
    logic [15:0] thr;
    reset_reader();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++)
      repeat (DIR_TAB[r].reps)
        send_item(DIR_TAB[r].mode, DIR_TAB[r].lines, DIR_TAB[r].typed, DIR_TAB[r].want);

    phase_idx = 0;
    while (run_items < RANDOM_ITEMS) begin
      case (phase_idx)
        0: thr = 16'd0;
        1: thr = TIME_MAX;
        default: begin
          case ($urandom_range(0, 9))
            0: thr = 16'd0;
            1: thr = TIME_MAX;
            2: thr = 16'($urandom);
            default: thr = 16'($urandom_range(0, 24));
          endcase
        end
      endcase
      write_threshold(thr);
      repeat (3) measure_run($urandom_range(0, 99) < 35, $urandom_range(0, 100));
      phase_idx++;
    end

    wait_idle();
    if (errors == 0 && pending_results.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
